/* sv/qksc_pkg.sv */
// Package for the query key schema checker: payload types, verdict codes,
// character codes and the key candidate table. No dependencies.
`timescale 1ns / 1ps

package qksc_pkg;

	// One input transfer: a byte of the query string and its framing flags.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       carries_byte;
		logic       end_of_string;
	} query_t;

	// One result transfer: the verdict for a whole string.
	typedef struct packed {
		logic [1:0]  verdict;
		logic [11:0] bad_key_offset;
		logic [11:0] bad_key_length;
	} result_t;

	localparam logic [1:0] VERDICT_OK       = 2'd0;
	localparam logic [1:0] VERDICT_UNKNOWN  = 2'd1;
	localparam logic [1:0] VERDICT_BAD_TYPE = 2'd2;

	localparam logic [7:0] CHAR_QMARK = 8'h3F;
	localparam logic [7:0] CHAR_AMP   = 8'h26;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_EQ    = 8'h3D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Candidate 0 is the exact key oss.asize, candidate 1 the exact key authz,
	// the rest are namespace prefixes.
	localparam int NUM_CAND     = 8;
	localparam int CAND_ASIZE   = 0;
	localparam int CAND_AUTHZ   = 1;
	localparam int FIRST_PREFIX = 2;

	localparam logic [0:7][0:9][7:0] CAND_TEXT = '{
		'{"o", "s", "s", ".", "a", "s", "i", "z", "e", 8'h00},
		'{"a", "u", "t", "h", "z", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"o", "s", "s", ".", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "p", "c", ".", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"x", "r", "d", ".", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"x", "r", "d", "c", "l", ".", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "m", "s", ".", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "c", "i", "t", "a", "g", ".", 8'h00, 8'h00, 8'h00}
	};

	localparam logic [0:7][3:0] CAND_LEN = '{
		4'd9, 4'd5, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4, 4'd7
	};

endpackage

/* sv/query_key_schema_checker.sv */
// Query key schema checker, top level. Uses qksc_pkg for payload types,
// verdict codes and the key candidate table.
`timescale 1ns / 1ps

// Usage
// The query channel carries one byte of a query string per transfer, with
// carries_byte marking a real byte and end_of_string closing the string
// (after the byte, if the transfer carries one). A transfer with neither flag
// set is consumed and changes nothing. Exactly one result transfer leaves on
// the result channel for every transfer that has end_of_string set; it holds
// the verdict and the offset and length of the first key that broke the
// schema, or zeros when the string is clean.
// Timing: an accepted transfer is held in the input register, the per-byte
// update and the verdict are computed from that register, and the verdict
// lands in the result register when the closing transfer moves on, which it
// does once the result register is empty or being taken.
// Throughput is one byte per cycle while no closing transfer is held back by
// a verdict that has not been taken.
// Stalls: the result register decouples the two sides. The input register
// keeps draining while the result register is empty or being taken, so the
// block keeps accepting bytes while a verdict waits; only a held verdict with
// a second verdict behind it stops the input.
// Reset: arst_n clears all parsing state, the input register valid bit and
// the result valid bit. After each verdict the parser returns to that state.
module query_key_schema_checker #(
	parameter int MAX_STRING_LEN = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_ready,
	input  qksc_pkg::query_t query,
	output logic             result_valid,
	input  logic             result_ready,
	output qksc_pkg::result_t result
);

	// Positions and key lengths saturate at this value.
	localparam int PosCapInt = (MAX_STRING_LEN - 1 < 4095) ? MAX_STRING_LEN - 1 : 4095;
	localparam logic [11:0] POS_CAP = 12'(PosCapInt);

	// Complete parser state for the string in progress.
	typedef struct packed {
		logic [11:0] pos;            // bytes received so far, saturating
		logic        first;          // next byte is the first of the string
		logic        in_value;       // past the first '=' of the segment
		logic [11:0] key_len;        // key bytes so far, saturating
		logic [11:0] seg_start;      // offset of the segment's first byte
		logic [7:0]  alive;          // candidates still matching the key
		logic        prefix_matched; // a namespace prefix matched in full
		logic        val_nonempty;
		logic        val_digits;
		logic        viol;           // a violation has been latched
		logic [1:0]  lat_verdict;
		logic [11:0] lat_off;
		logic [11:0] lat_len;
	} chk_state_t;

	localparam chk_state_t STATE_RESET = '{
		pos: 12'd0, first: 1'b1, in_value: 1'b0, key_len: 12'd0,
		seg_start: 12'd0, alive: 8'hFF, prefix_matched: 1'b0,
		val_nonempty: 1'b0, val_digits: 1'b1, viol: 1'b0,
		lat_verdict: qksc_pkg::VERDICT_OK, lat_off: 12'd0, lat_len: 12'd0
	};

	function automatic logic [11:0] sat_inc(input logic [11:0] v);
		return (v < POS_CAP) ? v + 12'd1 : POS_CAP;
	endfunction

	// Judge the segment that just ended and start a new one at next_start.
	function automatic chk_state_t close_seg(input chk_state_t s,
			input logic [11:0] next_start);
		chk_state_t r;
		logic       nonempty;
		logic       is_asize;
		logic       is_authz;
		logic [1:0] v;
		r = s;
		nonempty = s.in_value || (s.key_len != 12'd0);
		is_asize = s.alive[qksc_pkg::CAND_ASIZE] &&
			(s.key_len == 12'(qksc_pkg::CAND_LEN[qksc_pkg::CAND_ASIZE]));
		is_authz = s.alive[qksc_pkg::CAND_AUTHZ] &&
			(s.key_len == 12'(qksc_pkg::CAND_LEN[qksc_pkg::CAND_AUTHZ]));
		if (is_asize) begin
			v = (s.val_nonempty && s.val_digits) ? qksc_pkg::VERDICT_OK
				: qksc_pkg::VERDICT_BAD_TYPE;
		end else if (s.prefix_matched || is_authz) begin
			v = qksc_pkg::VERDICT_OK;
		end else begin
			v = qksc_pkg::VERDICT_UNKNOWN;
		end
		if (nonempty && !s.viol && (v != qksc_pkg::VERDICT_OK)) begin
			r.viol        = 1'b1;
			r.lat_verdict = v;
			r.lat_off     = s.seg_start;
			r.lat_len     = s.key_len;
		end
		r.in_value       = 1'b0;
		r.key_len        = 12'd0;
		r.alive          = 8'hFF;
		r.prefix_matched = 1'b0;
		r.val_nonempty   = 1'b0;
		r.val_digits     = 1'b1;
		r.seg_start      = next_start;
		return r;
	endfunction

	// Advance every live candidate by one key byte; the candidates are
	// independent comparators against the current key position.
	function automatic chk_state_t key_byte(input chk_state_t s, input logic [7:0] b);
		chk_state_t  r;
		logic [11:0] i;
		logic [11:0] len;
		r = s;
		i = s.key_len;
		for (int c = 0; c < qksc_pkg::NUM_CAND; c++) begin
			len = 12'(qksc_pkg::CAND_LEN[c]);
			if (s.alive[c]) begin
				if ((i < len) && (b == qksc_pkg::CAND_TEXT[c][(i < len) ? i[3:0] : 4'd0]))
						begin
					if ((c >= qksc_pkg::FIRST_PREFIX) && (i == len - 12'd1)) begin
						r.prefix_matched = 1'b1;
					end
				end else begin
					r.alive[c] = 1'b0;
				end
			end
		end
		r.key_len = sat_inc(s.key_len);
		return r;
	endfunction

	qksc_pkg::query_t  query_s1;
	logic              valid_s1;
	chk_state_t        st_q;
	chk_state_t        st_next;
	qksc_pkg::result_t res_next;
	qksc_pkg::result_t result_q;
	logic              result_valid_q;
	logic              advance;

	// A held transfer that produces no verdict always moves on. A closing
	// transfer waits until the result register is empty or being taken.
	assign advance     = valid_s1 &&
		(!query_s1.end_of_string || !result_valid_q || result_ready);
	assign query_ready = !valid_s1 || advance;

	always_comb begin
		logic first;
		logic [7:0] b;
		st_next  = st_q;
		res_next = '0;
		first    = st_q.first;
		b        = query_s1.data_byte;
		if (query_s1.carries_byte) begin
			st_next.pos   = sat_inc(st_q.pos);
			st_next.first = 1'b0;
			priority if (first && (b == qksc_pkg::CHAR_QMARK)) begin
				st_next.seg_start = st_next.pos;
			end else if ((b == qksc_pkg::CHAR_AMP) || (b == qksc_pkg::CHAR_SEMI)) begin
				st_next = close_seg(st_next, st_next.pos);
			end else if (st_q.in_value) begin
				st_next.val_nonempty = 1'b1;
				if ((b < qksc_pkg::CHAR_ZERO) || (b > qksc_pkg::CHAR_NINE)) begin
					st_next.val_digits = 1'b0;
				end
			end else if (b == qksc_pkg::CHAR_EQ) begin
				st_next.in_value = 1'b1;
			end else begin
				st_next = key_byte(st_next, b);
			end
		end
		if (query_s1.end_of_string) begin
			st_next = close_seg(st_next, st_next.pos);
			if (st_next.viol) begin
				res_next.verdict        = st_next.lat_verdict;
				res_next.bad_key_offset = st_next.lat_off;
				res_next.bad_key_length = st_next.lat_len;
			end
			st_next = STATE_RESET;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (query_ready) begin
			valid_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (query_valid && query_ready) begin
			query_s1 <= query;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && query_s1.end_of_string) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && query_s1.end_of_string) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A clean verdict never carries a key position.
	a_ok_has_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (result_q.verdict == qksc_pkg::VERDICT_OK)) |->
		((result_q.bad_key_offset == 12'd0) && (result_q.bad_key_length == 12'd0)))
		else $error("ok verdict with nonzero key offset or length");

	// Without a latched violation the latch fields stay at their clean values.
	a_latch_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.viol |-> ((st_q.lat_verdict == qksc_pkg::VERDICT_OK) &&
		(st_q.lat_off == 12'd0) && (st_q.lat_len == 12'd0)))
		else $error("latched verdict set without a violation");

	// Counters never pass the saturation point.
	a_pos_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.pos <= POS_CAP) && (st_q.key_len <= POS_CAP))
		else $error("position or key length beyond saturation");

	// A held transfer that cannot move on stays in the input register.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(query_s1)))
		else $error("stalled input register lost its transfer");

endmodule

/* dv/tb_query_key_schema_checker.sv */
// Testbench for the query key schema checker: feeds query strings byte by
// byte under random idling on both channels and checks every verdict.
// Depends on qksc_pkg and query_key_schema_checker.
`timescale 1ns / 1ps

module tb_query_key_schema_checker;

	localparam int STR_LIMIT = 4096;
	// Positions and key lengths stop counting here.
	localparam int POS_CAP = (STR_LIMIT - 1 < 4095) ? STR_LIMIT - 1 : 4095;
	// The longest known key is nine bytes, so only that many key bytes are kept.
	localparam int HEAD_LEN = 9;
	localparam int RANDOM_BYTES = 1080;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_DIRECTED = 25;

	localparam string KEY_CHARS = "abcdefghijklmnopqrstuvwxyzACOSTXZ0123456789._-?";
	localparam string VALUE_CHARS = "0123456789/:aZ.=?%+";
	localparam string DIGITS = "0123456789";
	localparam string RAW_SPECIALS = "?&;=9:/";

	typedef logic [7:0] byte_q_t [$];

	// One row of the directed table: the transfer to send and, on rows that
	// close a string with an obvious outcome, the verdict typed in by hand.
	typedef struct {
		qksc_pkg::query_t  item;
		bit                typed;
		qksc_pkg::result_t want;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              query_valid;
	logic              query_ready;
	qksc_pkg::query_t  query;
	logic              result_valid;
	logic              result_ready;
	qksc_pkg::result_t result;

	int send_idle_pct = 22;
	int recv_idle_pct = 77;
	bit stall_request = 1'b0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int bytes_sent = 0;

	// Known keys: the exact key with a typed value, the exact key authz, and
	// the namespace prefixes, indexed by the candidate numbers of the package.
	string key_names [qksc_pkg::NUM_CAND] = '{
		"oss.asize", "authz", "oss.", "tpc.", "xrd.", "xrdcl.", "cms.", "scitag."
	};

	// Verdict predictor state. The key is judged when its segment closes, from
	// its first bytes and its length, rather than by a running candidate mask.
	logic [11:0]       pos_count;
	logic [11:0]       seg_start;
	logic [11:0]       key_len;
	logic              first_byte;
	logic              in_value;
	logic              val_nonempty;
	logic              val_digits;
	logic              bad_seen;
	logic [7:0]        key_head [HEAD_LEN];
	qksc_pkg::result_t first_bad;

	// Verdicts still owed by the block, oldest first.
	qksc_pkg::result_t verdict_q [$];

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		// A transfer with neither a byte nor an end marker does nothing.
		'{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
		// Empty string: a bare end marker alone is clean. Its data byte is ignored.
		'{'{8'hFF, 1'b0, 1'b1}, 1'b1, '{qksc_pkg::VERDICT_OK, 12'd0, 12'd0}},
		// A segment made of "=" alone has an empty key, which is unknown.
		'{'{qksc_pkg::CHAR_EQ, 1'b1, 1'b1}, 1'b1,
			'{qksc_pkg::VERDICT_UNKNOWN, 12'd0, 12'd0}},
		// "??" and a zero byte: only the leading '?' is skipped, so the key is
		// the second '?' and the zero byte, starting at offset 1.
		'{'{qksc_pkg::CHAR_QMARK, 1'b1, 1'b0}, 1'b0, '0},
		'{'{qksc_pkg::CHAR_QMARK, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h00, 1'b0, 1'b1}, 1'b1, '{qksc_pkg::VERDICT_UNKNOWN, 12'd1, 12'd2}},
		// "oss.asize=" with an empty value is a bad value type.
		'{'{"o", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"s", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"s", 1'b1, 1'b0}, 1'b0, '0},
		'{'{".", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"a", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"s", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"i", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"z", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"e", 1'b1, 1'b0}, 1'b0, '0},
		'{'{qksc_pkg::CHAR_EQ, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h00, 1'b0, 1'b1}, 1'b1, '{qksc_pkg::VERDICT_BAD_TYPE, 12'd0, 12'd9}},
		// "&" then 0xFF: the empty first segment passes, the one-byte key does not.
		'{'{qksc_pkg::CHAR_AMP, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'hFF, 1'b1, 1'b1}, 1'b1, '{qksc_pkg::VERDICT_UNKNOWN, 12'd1, 12'd1}},
		// "authz" exactly, with the end marker on its last byte.
		'{'{"a", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"u", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"t", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"h", 1'b1, 1'b0}, 1'b0, '0},
		'{'{"z", 1'b1, 1'b1}, 1'b1, '{qksc_pkg::VERDICT_OK, 12'd0, 12'd0}}
	};

	query_key_schema_checker #(
		.MAX_STRING_LEN(STR_LIMIT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query        (query),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [11:0] sat_inc(logic [11:0] v);
		return (v < 12'(POS_CAP)) ? v + 12'd1 : 12'(POS_CAP);
	endfunction

	// True when the current key is at least as long as s and begins with it.
	function automatic bit key_starts_with(string s);
		if (key_len < 12'(s.len()))
			return 1'b0;
		for (int i = 0; i < s.len(); i++) begin
			if (key_head[i] != s[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit key_equals(string s);
		return key_len == 12'(s.len()) && key_starts_with(s);
	endfunction

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	task automatic clear_segment();
		in_value = 1'b0;
		key_len = '0;
		val_nonempty = 1'b0;
		val_digits = 1'b1;
	endtask

	task automatic reset_parser();
		pos_count = '0;
		first_byte = 1'b1;
		seg_start = '0;
		bad_seen = 1'b0;
		first_bad = '0;
		clear_segment();
	endtask

	// Judges the segment that just ended and starts the next one at next_start.
	// Only the first violation of a string is kept.
	task automatic close_segment(logic [11:0] next_start);
		logic [1:0] v;
		if ((in_value || key_len != 0) && !bad_seen) begin
			v = qksc_pkg::VERDICT_UNKNOWN;
			if (key_equals(key_names[qksc_pkg::CAND_ASIZE])) begin
				v = (val_nonempty && val_digits) ? qksc_pkg::VERDICT_OK
					: qksc_pkg::VERDICT_BAD_TYPE;
			end else begin
				if (key_equals(key_names[qksc_pkg::CAND_AUTHZ]))
					v = qksc_pkg::VERDICT_OK;
				for (int c = qksc_pkg::FIRST_PREFIX; c < qksc_pkg::NUM_CAND; c++) begin
					if (key_starts_with(key_names[c]))
						v = qksc_pkg::VERDICT_OK;
				end
			end
			if (v != qksc_pkg::VERDICT_OK) begin
				bad_seen = 1'b1;
				first_bad = '{v, seg_start, key_len};
			end
		end
		clear_segment();
		seg_start = next_start;
	endtask

	// Advances the predictor by one accepted transfer and queues the verdict
	// when the transfer ends a string.
	task automatic schema_step(qksc_pkg::query_t q);
		logic       was_first;
		logic [7:0] b;
		b = q.data_byte;
		if (q.carries_byte) begin
			was_first = first_byte;
			pos_count = sat_inc(pos_count);
			first_byte = 1'b0;
			if (was_first && b == qksc_pkg::CHAR_QMARK) begin
				seg_start = pos_count;
			end else if (b == qksc_pkg::CHAR_AMP || b == qksc_pkg::CHAR_SEMI) begin
				close_segment(pos_count);
			end else if (in_value) begin
				val_nonempty = 1'b1;
				if (b < qksc_pkg::CHAR_ZERO || b > qksc_pkg::CHAR_NINE)
					val_digits = 1'b0;
			end else if (b == qksc_pkg::CHAR_EQ) begin
				in_value = 1'b1;
			end else begin
				if (key_len < HEAD_LEN)
					key_head[key_len[3:0]] = b;
				key_len = sat_inc(key_len);
			end
		end
		if (q.end_of_string) begin
			close_segment(pos_count);
			verdict_q.push_back(bad_seen ? first_bad : qksc_pkg::result_t'('0));
			reset_parser();
		end
	endtask

	// Offers one transfer on the query channel. Called at a falling edge and
	// returns at a falling edge. Random idle cycles come first, with valid low;
	// once valid rises it stays up with the same payload until the transfer.
	// A typed verdict, when given, replaces the predicted one for this string.
	task automatic offer(qksc_pkg::query_t item, bit typed, qksc_pkg::result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			query_valid <= 1'b0;
			@(negedge clk);
		end
		query <= item;
		query_valid <= 1'b1;
		do @(posedge clk); while (!query_ready);
		schema_step(item);
		if (typed)
			verdict_q[verdict_q.size() - 1] = want;
		@(negedge clk);
	endtask

	// Sends a whole string. A few empty transfers with random data are mixed
	// in; the end marker rides on the last byte or follows as a bare marker.
	task automatic send_string(byte_q_t text, bit bare_end);
		qksc_pkg::query_t item;
		for (int i = 0; i < text.size(); i++) begin
			if ($urandom_range(99) < 3) begin
				item = '{8'($urandom_range(255)), 1'b0, 1'b0};
				offer(item, 1'b0, '0);
			end
			item = '{text[i], 1'b1, !bare_end && i == text.size() - 1};
			offer(item, 1'b0, '0);
			bytes_sent++;
		end
		if (bare_end || text.size() == 0) begin
			item = '{8'($urandom_range(255)), 1'b0, 1'b1};
			offer(item, 1'b0, '0);
		end
	endtask

	// Lowers valid and waits until the block has returned every verdict owed.
	// The first wait always advances a step, so valid is not driven twice at
	// the same edge when the next transfer is offered right away.
	task automatic wait_drained();
		query_valid <= 1'b0;
		do @(negedge clk); while (verdict_q.size() != 0);
	endtask

	task automatic append_text(inout byte_q_t s, input string t);
		for (int i = 0; i < t.len(); i++)
			s.push_back(t[i]);
	endtask

	task automatic append_value(inout byte_q_t s, input bit digits_only);
		s.push_back(qksc_pkg::CHAR_EQ);
		repeat (digits_only ? $urandom_range(1, 5) : $urandom_range(5))
			s.push_back(pick(digits_only ? DIGITS : VALUE_CHARS));
	endtask

	// Adds one segment, mostly keys that are accepted or nearly accepted, so
	// that the candidate matching is exercised deep into each key.
	task automatic append_segment(inout byte_q_t s);
		string name;
		int    n;
		case ($urandom_range(9))
			0, 1, 2: begin
				append_text(s,
					key_names[$urandom_range(qksc_pkg::FIRST_PREFIX, qksc_pkg::NUM_CAND - 1)]);
				repeat ($urandom_range(4))
					s.push_back(pick(KEY_CHARS));
				if ($urandom_range(1))
					append_value(s, 1'b0);
			end
			3: begin
				append_text(s, key_names[qksc_pkg::CAND_AUTHZ]);
				if ($urandom_range(1))
					append_value(s, 1'b0);
			end
			4: begin
				append_text(s, key_names[qksc_pkg::CAND_ASIZE]);
				append_value(s, 1'b1);
			end
			5: begin
				// The typed key with a missing, empty or non-numeric value.
				// The characters just outside the digit range are favored.
				append_text(s, key_names[qksc_pkg::CAND_ASIZE]);
				case ($urandom_range(2))
					0: ;
					1: s.push_back(qksc_pkg::CHAR_EQ);
					default: begin
						append_value(s, 1'b1);
						s.push_back(pick("x/:.-"));
					end
				endcase
			end
			6: begin
				// Near misses: a known key cut short or with one byte too many.
				name = key_names[$urandom_range(qksc_pkg::NUM_CAND - 1)];
				if ($urandom_range(1)) begin
					n = $urandom_range(1, name.len() - 1);
					for (int i = 0; i < n; i++)
						s.push_back(name[i]);
				end else begin
					append_text(s, name);
					s.push_back(pick(KEY_CHARS));
				end
				if ($urandom_range(1))
					append_value(s, 1'b0);
			end
			7: ;
			8: append_value(s, 1'b0);
			default: begin
				repeat ($urandom_range(1, 6))
					s.push_back(8'($urandom_range(255)));
			end
		endcase
	endtask

	// Builds one random string. Most are well formed: an optional leading '?'
	// and a few segments split by '&' or ';'. The rest are raw bytes.
	task automatic make_query(output byte_q_t text);
		int segs;
		text = {};
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(12))
				text.push_back($urandom_range(1) ? 8'($urandom_range(255)) : pick(RAW_SPECIALS));
		end else begin
			if ($urandom_range(2) == 0)
				text.push_back(qksc_pkg::CHAR_QMARK);
			segs = $urandom_range(1, 4);
			for (int k = 0; k < segs; k++) begin
				if (k != 0)
					text.push_back($urandom_range(1) ? qksc_pkg::CHAR_AMP : qksc_pkg::CHAR_SEMI);
				append_segment(text);
			end
			if ($urandom_range(9) == 0)
				text.push_back(qksc_pkg::CHAR_AMP);
		end
	endtask

	// Sends random strings with the given idle rates until the byte budget is
	// spent, then waits for the last verdict.
	task automatic run_phase(int send_pct, int recv_pct, int budget);
		byte_q_t text;
		int      start;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			make_query(text);
			send_string(text, 1'(($urandom_range(1))));
		end
		wait_drained();
	endtask

	// Result side. The ready line moves at falling edges with the current idle
	// rate. On request it is held low for a long stretch, counted here, so
	// that verdicts back up and the block stops taking bytes.
	initial begin : drive_result_ready
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Each verdict transfer is compared with the oldest verdict owed. Values
	// read here are those from just before the rising edge.
	always @(posedge clk) begin : check_verdicts
		qksc_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (verdict_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("Unexpected verdict transfer: verdict=%0d offset=%0d length=%0d",
						result.verdict, result.bad_key_offset, result.bad_key_length);
				mismatch_count++;
			end else begin
				want = verdict_q.pop_front();
				if (result.verdict !== want.verdict
						|| result.bad_key_offset !== want.bad_key_offset
						|| result.bad_key_length !== want.bad_key_length) begin
					if (mismatch_count < 10)
						$display("Verdict mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							want.verdict, want.bad_key_offset, want.bad_key_length,
							result.verdict, result.bad_key_offset, result.bad_key_length);
					mismatch_count++;
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		query_valid = 1'b0;
		query = '0;
		reset_parser();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed table first, under the first idling pattern.
		foreach (directed_rows[r])
			offer(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

		// Random strings: slow receiver, then slow sender, then full speed.
		// The sender pauses at the end of each phase until all verdicts are in.
		run_phase(22, 77, RANDOM_BYTES / 3);
		run_phase(77, 22, RANDOM_BYTES / 3);
		stall_request = 1'b1;
		run_phase(0, 0, RANDOM_BYTES - 2 * (RANDOM_BYTES / 3));

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && verdict_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/qksc_pkg.sv
sv/query_key_schema_checker.sv
dv/tb_query_key_schema_checker.sv
